### hw/rtl/dns_response_a_record_parser_core_macros.svh
// ----------------------------------------------------------------------------
// DNS A-record parser assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef DNS_RESPONSE_A_RECORD_PARSER_CORE_MACROS_SVH
`define DNS_RESPONSE_A_RECORD_PARSER_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DNSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define DNSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/dnsp_pkg.sv
// ----------------------------------------------------------------------------
// DNS A-record parser package
// Shared constants, result kinds and the result and queue status structs.
// ----------------------------------------------------------------------------
package dnsp_pkg;

   localparam int unsigned MAX_MESSAGE_BYTES = 2048;
   // byte offset saturates one past the limit
   localparam int unsigned OFFSET_W          = $clog2(MAX_MESSAGE_BYTES + 2);

   localparam int unsigned Q_DEPTH   = 4;
   localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int unsigned Q_COUNT_W = $clog2(Q_DEPTH + 1);

   localparam int unsigned HDR_BYTES   = 12;
   localparam int unsigned QFIX_BYTES  = 4;
   localparam int unsigned AFIX_BYTES  = 10;
   localparam logic [7:0]  PTR_MASK    = 8'hc0;
   localparam logic [15:0] TYPE_A      = 16'd1;
   localparam logic [15:0] CLASS_IN    = 16'd1;
   localparam logic [15:0] A_DATA_LEN  = 16'd4;

   localparam int unsigned RSP_TDATA_W = 88;

   typedef enum logic [1:0] {
      KIND_A_RECORD = 2'd0,
      KIND_END_OK   = 2'd1,
      KIND_END_RCODE = 2'd2,
      KIND_END_BAD  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] ttl;
      logic [31:0] ipv4_address;
      logic [3:0]  response_code;
      logic [15:0] records_found;
      logic        last_of_run;
   } result_type;

   // results raised by one byte, in delivery order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic [Q_COUNT_W-1:0] count;
   } queue_status_type;

endpackage

### hw/rtl/dnsp_parser.sv
// ----------------------------------------------------------------------------
// DNS A-record parser byte engine
// Holds the message walk state and turns one accepted byte into results.
// ----------------------------------------------------------------------------
module dnsp_parser
   import dnsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output push_type   push
);

   typedef enum logic [9:0] {
      PH_HDR    = 10'b00_0000_0001,
      PH_QNAME  = 10'b00_0000_0010,
      PH_QPTR   = 10'b00_0000_0100,
      PH_QFIX   = 10'b00_0000_1000,
      PH_ANAME  = 10'b00_0001_0000,
      PH_APTR   = 10'b00_0010_0000,
      PH_AFIX   = 10'b00_0100_0000,
      PH_ADATA  = 10'b00_1000_0000,
      PH_DONE   = 10'b01_0000_0000,
      PH_IGNORE = 10'b10_0000_0000
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [15:0]          step_ff, step_in;
   logic [15:0]          questions_ff, questions_in;
   logic [15:0]          answers_ff, answers_in;
   logic [5:0]           label_ff, label_in;
   logic [3:0]           rcode_ff, rcode_in;
   logic [15:0]          rtype_ff, rtype_in;
   logic [15:0]          rclass_ff, rclass_in;
   logic [31:0]          ttl_ff, ttl_in;
   logic [15:0]          dlen_ff, dlen_in;
   logic [31:0]          addr_ff, addr_in;
   logic [15:0]          found_ff, found_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;

   logic                 a_valid;
   result_type           a_res;
   logic                 end_valid;
   result_type           end_res;

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      questions_in = questions_ff;
      answers_in   = answers_ff;
      label_in     = label_ff;
      rcode_in     = rcode_ff;
      rtype_in     = rtype_ff;
      rclass_in    = rclass_ff;
      ttl_in       = ttl_ff;
      dlen_in      = dlen_ff;
      addr_in      = addr_ff;
      found_in     = found_ff;
      offset_in    = offset_ff;
      a_valid      = 1'b0;
      end_valid    = 1'b0;
      a_res        = '0;
      end_res      = '0;

      if (fire) begin
         if (offset_ff < OFFSET_W'(MAX_MESSAGE_BYTES)) begin
            offset_in = offset_ff + OFFSET_W'(1);
            unique case (phase_ff)
               PH_HDR: begin
                  if (step_ff == 16'd3) begin
                     rcode_in = data_byte[3:0];
                  end else if (step_ff == 16'd4 || step_ff == 16'd5) begin
                     questions_in = {questions_ff[7:0], data_byte};
                  end else if (step_ff == 16'd6 || step_ff == 16'd7) begin
                     answers_in = {answers_ff[7:0], data_byte};
                  end
                  step_in = step_ff + 16'd1;
                  if (step_in >= 16'(HDR_BYTES)) begin
                     if (rcode_in != 4'd0) begin
                        phase_in = PH_IGNORE;
                     end else begin
                        step_in  = '0;
                        label_in = '0;
                        if (questions_in != 16'd0) phase_in = PH_QNAME;
                        else if (answers_in != 16'd0) phase_in = PH_ANAME;
                        else phase_in = PH_DONE;
                     end
                  end
               end
               PH_QNAME, PH_ANAME: begin
                  if (label_ff != 6'd0) begin
                     label_in = label_ff - 6'd1;
                  end else if ((data_byte & PTR_MASK) == PTR_MASK) begin
                     phase_in = (phase_ff == PH_QNAME) ? PH_QPTR : PH_APTR;
                  end else if (data_byte[5:0] == 6'd0) begin
                     // root label ends the name
                     phase_in = (phase_ff == PH_QNAME) ? PH_QFIX : PH_AFIX;
                     step_in  = '0;
                  end else begin
                     label_in = data_byte[5:0];
                  end
               end
               PH_QPTR: begin
                  phase_in = PH_QFIX;
                  step_in  = '0;
               end
               PH_APTR: begin
                  phase_in = PH_AFIX;
                  step_in  = '0;
               end
               PH_QFIX: begin
                  step_in = step_ff + 16'd1;
                  if (step_in >= 16'(QFIX_BYTES)) begin
                     questions_in = questions_ff - 16'd1;
                     step_in      = '0;
                     label_in     = '0;
                     if (questions_in != 16'd0) phase_in = PH_QNAME;
                     else if (answers_ff != 16'd0) phase_in = PH_ANAME;
                     else phase_in = PH_DONE;
                  end
               end
               PH_AFIX: begin
                  if (step_ff < 16'd2) rtype_in = {rtype_ff[7:0], data_byte};
                  else if (step_ff < 16'd4) rclass_in = {rclass_ff[7:0], data_byte};
                  else if (step_ff < 16'd8) ttl_in = {ttl_ff[23:0], data_byte};
                  else dlen_in = {dlen_ff[7:0], data_byte};
                  step_in = step_ff + 16'd1;
                  if (step_in >= 16'(AFIX_BYTES)) begin
                     step_in = '0;
                     addr_in = '0;
                     if (dlen_in == 16'd0) begin
                        answers_in = answers_ff - 16'd1;
                        label_in   = '0;
                        phase_in   = (answers_in != 16'd0) ? PH_ANAME : PH_DONE;
                     end else begin
                        phase_in = PH_ADATA;
                     end
                  end
               end
               PH_ADATA: begin
                  addr_in = {addr_ff[23:0], data_byte};
                  step_in = step_ff + 16'd1;
                  if (step_in >= dlen_ff) begin
                     if (rtype_ff == TYPE_A && rclass_ff == CLASS_IN &&
                         dlen_ff == A_DATA_LEN) begin
                        found_in                = found_ff + 16'd1;
                        a_valid                 = 1'b1;
                        a_res.kind              = KIND_A_RECORD;
                        a_res.ttl               = ttl_ff;
                        a_res.ipv4_address      = addr_in;
                        a_res.response_code     = rcode_ff;
                        a_res.records_found     = found_in;
                        a_res.last_of_run       = ~last_byte;
                     end
                     answers_in = answers_ff - 16'd1;
                     step_in    = '0;
                     label_in   = '0;
                     phase_in   = (answers_in != 16'd0) ? PH_ANAME : PH_DONE;
                  end
               end
               PH_DONE, PH_IGNORE: begin
               end
               default: begin
               end
            endcase
         end else begin
            offset_in = OFFSET_W'(MAX_MESSAGE_BYTES + 1);
         end

         if (last_byte) begin
            end_valid = 1'b1;
            priority if (phase_in == PH_HDR) end_res.kind = KIND_END_BAD;
            else if (rcode_in != 4'd0) end_res.kind = KIND_END_RCODE;
            else if (offset_in > OFFSET_W'(MAX_MESSAGE_BYTES)) end_res.kind = KIND_END_BAD;
            else if (phase_in != PH_DONE) end_res.kind = KIND_END_BAD;
            else end_res.kind = KIND_END_OK;
            end_res.response_code = (phase_in == PH_HDR) ? 4'd0 : rcode_in;
            end_res.records_found = found_in;
            end_res.last_of_run   = 1'b1;

            // back to the header for the next datagram
            phase_in     = PH_HDR;
            step_in      = '0;
            questions_in = '0;
            answers_in   = '0;
            label_in     = '0;
            rcode_in     = '0;
            rtype_in     = '0;
            rclass_in    = '0;
            ttl_in       = '0;
            dlen_in      = '0;
            addr_in      = '0;
            found_in     = '0;
            offset_in    = '0;
         end
      end
   end

   always_comb begin
      push.count  = 2'(a_valid) + 2'(end_valid);
      push.first  = a_valid ? a_res : end_res;
      push.second = end_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR;
         step_ff      <= '0;
         questions_ff <= '0;
         answers_ff   <= '0;
         label_ff     <= '0;
         rcode_ff     <= '0;
         rtype_ff     <= '0;
         rclass_ff    <= '0;
         ttl_ff       <= '0;
         dlen_ff      <= '0;
         addr_ff      <= '0;
         found_ff     <= '0;
         offset_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         questions_ff <= questions_in;
         answers_ff   <= answers_in;
         label_ff     <= label_in;
         rcode_ff     <= rcode_in;
         rtype_ff     <= rtype_in;
         rclass_ff    <= rclass_in;
         ttl_ff       <= ttl_in;
         dlen_ff      <= dlen_in;
         addr_ff      <= addr_in;
         found_ff     <= found_in;
         offset_ff    <= offset_in;
      end
   end

endmodule

### hw/rtl/dnsp_res_queue.sv
// ----------------------------------------------------------------------------
// DNS A-record parser result queue
// Small result FIFO taking up to two results a cycle, one out per beat.
// ----------------------------------------------------------------------------
module dnsp_res_queue
   import dnsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop_ready,
   output logic             head_valid,
   output result_type       head,
   output queue_status_type status
);

   result_type           entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ff, wr_in;
   logic [Q_PTR_W-1:0]   rd_ff, rd_in;
   logic [Q_COUNT_W-1:0] count_ff, count_in;
   logic                 pop;
   logic [Q_PTR_W-1:0]   wr_next;

   assign head_valid   = (count_ff != '0);
   assign head         = entry_ff[rd_ff];
   assign status.count = count_ff;
   assign pop          = head_valid & pop_ready;
   assign wr_next      = wr_ff + Q_PTR_W'(1);

   always_comb begin
      wr_in    = wr_ff + Q_PTR_W'(push.count);
      rd_in    = rd_ff + Q_PTR_W'(pop);
      count_in = count_ff + Q_COUNT_W'(push.count) - Q_COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

### hw/rtl/dns_response_a_record_parser_core.sv
// ----------------------------------------------------------------------------
// DNS response A-record parser core
// Results are registered into the result queue and offered from its head in order.
// Throughput: one byte per cycle; a byte raising two results (A record plus
// end) adds one output beat, absorbed by the four-entry result queue.
// Input stalls only while fewer than two queue entries are free.
// Reset: synchronous, active high; returns to the header phase, queue empty.
// ----------------------------------------------------------------------------
`include "dns_response_a_record_parser_core_macros.svh"

module dns_response_a_record_parser_core
   import dnsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic                   req_tlast,   // last_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] ttl, [63:32] ipv4_address,
                                               // [67:64] response_code,
                                               // [83:68] records_found, [87:84] zero
   output logic [1:0]             rsp_tuser,   // [1:0] kind
   output logic                   rsp_tlast    // last_of_run
);

   logic             req_fire;
   push_type         push;
   result_type       head;
   queue_status_type q_status;

   // room for the worst case of two results per beat
   assign req_tready = (q_status.count <= Q_COUNT_W'(Q_DEPTH - 2));
   assign req_fire   = req_tvalid & req_tready;

   dnsp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .push      (push)
   );

   dnsp_res_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .status     (q_status)
   );

   assign rsp_tdata = {4'b0000, head.records_found, head.response_code,
                       head.ipv4_address, head.ttl};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_of_run;

   `DNSP_ASSERT_NOW(a_queue_bound, 1'b1, q_status.count <= Q_COUNT_W'(Q_DEPTH), "result queue overflow")
   `DNSP_ASSERT_NOW(a_push_room, push.count != 2'd0, req_fire, "results raised without an accepted beat")
   `DNSP_ASSERT_NEXT(a_end_result, req_fire && req_tlast, rsp_tvalid, "final byte raised no end result")

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DNS response A-record parser testbench
// Feeds DNS responses one byte per beat: a short fixed table, then random
// well-formed, cut, miscounted, rcode and noise frames. Each report is predicted
// in the bench (listed for the fixed table) and compared per field.
// ----------------------------------------------------------------------------
module testbench;
   import dnsp_pkg::*;

   localparam logic [7:0]  LABEL_PTR      = 8'hc0;
   localparam logic [7:0]  LABEL_EXT_01   = 8'h40;
   localparam logic [7:0]  LABEL_EXT_10   = 8'h80;
   localparam logic [7:0]  LABEL_LEN_MASK = 8'h3f;
   localparam logic [15:0] TYPE_HOST_ADDR = 16'd1;
   localparam logic [15:0] CLASS_INET     = 16'd1;
   localparam logic [15:0] ADDR_LEN       = 16'd4;

   typedef enum logic [3:0] {
      ST_HEADER, ST_QNAME, ST_QPTR, ST_QFIXED, ST_ANAME, ST_APTR, ST_AFIXED,
      ST_ADATA, ST_DONE, ST_IGNORE
   } parse_phase_type;

   typedef enum {MSG_CLEAN, MSG_RCODE, MSG_CUT, MSG_MISCOUNT, MSG_NOISE} msg_shape_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'h00;   // [7:0] data_byte
   logic                   req_tlast = 1'b0;    // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;           // [31:0] ttl, [63:32] ipv4_address,
                                                // [67:64] response_code,
                                                // [83:68] records_found, [87:84] zero
   logic [1:0]             rsp_tuser;           // [1:0] kind
   logic                   rsp_tlast;           // last_of_run

   // predicted parser state
   parse_phase_type parse_phase;
   int unsigned     field_step;
   logic [15:0]     q_left;
   logic [15:0]     a_left;
   logic [5:0]      lbl_left;
   logic [3:0]      hdr_rcode;
   logic [15:0]     rr_type;
   logic [15:0]     rr_class;
   logic [31:0]     rr_ttl;
   logic [15:0]     rd_len;
   logic [31:0]     rd_acc;
   logic [15:0]     a_found;
   int unsigned     msg_offset;

   result_type byte_reports [2];
   result_type pending_reports [$];
   logic [7:0] frame [$];

   bit          quiet = 1'b0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          stall_left = 0;
   int          typed_idx = 0;
   int unsigned bytes_sent = 0;
   int          frames_sent = 0;
   int          fail_count = 0;
   int          kind_seen [4];

   // fixed frames: a lone final byte, then one A record whose last data byte
   // is also the final byte, so both reports come from one beat
   logic [8:0] directed_rows [29] = '{
      {1'b1, 8'hff},
      {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h81}, {1'b0, 8'h80},
      {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h01},
      {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00},
      {1'b0, 8'hc0}, {1'b0, 8'h0c},
      {1'b0, 8'h00}, {1'b0, 8'h01}, {1'b0, 8'h00}, {1'b0, 8'h01},
      {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b0, 8'hff},
      {1'b0, 8'h00}, {1'b0, 8'h04},
      {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b1, 8'hff}
   };

   result_type directed_reports [3] = '{
      '{KIND_END_BAD,  32'h0000_0000, 32'h0000_0000, 4'h0, 16'd0, 1'b1},
      '{KIND_A_RECORD, 32'hffff_ffff, 32'hffff_ffff, 4'h0, 16'd1, 1'b0},
      '{KIND_END_OK,   32'h0000_0000, 32'h0000_0000, 4'h0, 16'd1, 1'b1}
   };

   dns_response_a_record_parser_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_state();
      parse_phase = ST_HEADER;
      field_step  = 0;
      q_left      = '0;
      a_left      = '0;
      lbl_left    = '0;
      hdr_rcode   = '0;
      rr_type     = '0;
      rr_class    = '0;
      rr_ttl      = '0;
      rd_len      = '0;
      rd_acc      = '0;
      a_found     = '0;
      msg_offset  = 0;
   endfunction

   function automatic void next_answer();
      field_step  = 0;
      lbl_left    = '0;
      parse_phase = (a_left != 0) ? ST_ANAME : ST_DONE;
   endfunction

   function automatic void next_question();
      field_step = 0;
      lbl_left   = '0;
      if (q_left != 0) parse_phase = ST_QNAME;
      else next_answer();
   endfunction

   // true when this byte closes the name
   function automatic bit name_ends(input logic [7:0] b, input parse_phase_type ptr_phase);
      if (lbl_left != 0) begin
         lbl_left--;
         return 1'b0;
      end
      if ((b & LABEL_PTR) == LABEL_PTR) begin
         parse_phase = ptr_phase;
         return 1'b0;
      end
      if ((b & LABEL_LEN_MASK) == 8'h00) return 1'b1;
      lbl_left = 6'(b & LABEL_LEN_MASK);
      return 1'b0;
   endfunction

   // advances the predicted state by one byte, fills byte_reports, returns count
   function automatic int parse_dns_byte(input logic [7:0] b, input logic last);
      int       n;
      kind_type end_kind;
      n = 0;
      if (msg_offset < MAX_MESSAGE_BYTES) begin
         msg_offset++;
         case (parse_phase)
            ST_HEADER: begin
               if (field_step == 3) hdr_rcode = b[3:0];
               else if (field_step == 4 || field_step == 5) q_left = {q_left[7:0], b};
               else if (field_step == 6 || field_step == 7) a_left = {a_left[7:0], b};
               field_step++;
               if (field_step >= 12) begin
                  if (hdr_rcode != 0) parse_phase = ST_IGNORE;
                  else next_question();
               end
            end
            ST_QNAME: begin
               if (name_ends(b, ST_QPTR)) begin
                  parse_phase = ST_QFIXED;
                  field_step  = 0;
               end
            end
            ST_QPTR: begin
               parse_phase = ST_QFIXED;
               field_step  = 0;
            end
            ST_QFIXED: begin
               field_step++;
               if (field_step >= 4) begin
                  q_left--;
                  next_question();
               end
            end
            ST_ANAME: begin
               if (name_ends(b, ST_APTR)) begin
                  parse_phase = ST_AFIXED;
                  field_step  = 0;
               end
            end
            ST_APTR: begin
               parse_phase = ST_AFIXED;
               field_step  = 0;
            end
            ST_AFIXED: begin
               if (field_step < 2) rr_type = {rr_type[7:0], b};
               else if (field_step < 4) rr_class = {rr_class[7:0], b};
               else if (field_step < 8) rr_ttl = {rr_ttl[23:0], b};
               else rd_len = {rd_len[7:0], b};
               field_step++;
               if (field_step >= 10) begin
                  field_step = 0;
                  rd_acc     = '0;
                  if (rd_len == 0) begin
                     a_left--;
                     next_answer();
                  end else begin
                     parse_phase = ST_ADATA;
                  end
               end
            end
            ST_ADATA: begin
               rd_acc = {rd_acc[23:0], b};
               field_step++;
               if (field_step >= rd_len) begin
                  if (rr_type == TYPE_HOST_ADDR && rr_class == CLASS_INET &&
                      rd_len == ADDR_LEN) begin
                     a_found++;
                     byte_reports[n] = '{KIND_A_RECORD, rr_ttl, rd_acc, hdr_rcode, a_found, 1'b0};
                     n++;
                  end
                  a_left--;
                  next_answer();
               end
            end
            default: begin
            end
         endcase
      end else begin
         msg_offset = MAX_MESSAGE_BYTES + 1;
      end

      if (last) begin
         if (parse_phase == ST_HEADER) end_kind = KIND_END_BAD;
         else if (hdr_rcode != 0) end_kind = KIND_END_RCODE;
         else if (msg_offset > MAX_MESSAGE_BYTES) end_kind = KIND_END_BAD;
         else if (parse_phase != ST_DONE) end_kind = KIND_END_BAD;
         else end_kind = KIND_END_OK;
         byte_reports[n] = '{end_kind, 32'd0, 32'd0,
                             (parse_phase == ST_HEADER) ? 4'd0 : hdr_rcode, a_found, 1'b1};
         n++;
         clear_state();
      end else if (n > 0) begin
         byte_reports[n-1].last_of_run = 1'b1;
      end
      return n;
   endfunction

   // ---------------------------------------------------------------- frame builders

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void put_byte(input logic [7:0] value);
      frame.insert(frame.size(), value);
   endfunction

   function automatic int pick_rate();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 6;
         default: return 30;
      endcase
   endfunction

   // labels (some with reserved prefixes, now and then a long one), then a
   // terminator: zero, a reserved zero length or a two-byte pointer
   function automatic void add_name();
      int unsigned len;
      logic [7:0]  prefix;
      repeat ($urandom_range(0, 3)) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 63) : $urandom_range(1, 6);
         case ($urandom_range(0, 7))
            0: prefix = LABEL_EXT_01;
            1: prefix = LABEL_EXT_10;
            default: prefix = 8'h00;
         endcase
         put_byte(prefix | 8'(len));
         repeat (len) put_byte(rnd8());
      end
      case ($urandom_range(0, 7))
         4, 5: begin
            put_byte(LABEL_PTR | 8'($urandom_range(0, 63)));
            put_byte(rnd8());
         end
         6: put_byte(LABEL_EXT_01);
         7: put_byte(LABEL_EXT_10);
         default: put_byte(8'h00);
      endcase
   endfunction

   function automatic void add_answer();
      logic [15:0] rtype;
      logic [15:0] rclass;
      logic [15:0] rlen;
      rtype  = TYPE_HOST_ADDR;
      rclass = CLASS_INET;
      rlen   = ADDR_LEN;
      case ($urandom_range(0, 9))
         6: begin
            rtype  = {rnd8(), rnd8()};
            rclass = {rnd8(), rnd8()};
            rlen   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8))
                                                 : 16'($urandom_range(256, 300));
         end
         7: rlen   = 16'($urandom_range(0, 8));
         8: rclass = {rnd8(), 8'h01};
         9: rtype  = {8'($urandom_range(1, 255)), 8'h01};
         default: begin
         end
      endcase
      add_name();
      put_byte(rtype[15:8]);
      put_byte(rtype[7:0]);
      put_byte(rclass[15:8]);
      put_byte(rclass[7:0]);
      repeat (4) put_byte(rnd8());
      put_byte(rlen[15:8]);
      put_byte(rlen[7:0]);
      repeat (rlen) put_byte(rnd8());
   endfunction

   function automatic void build_message(input msg_shape_type shape);
      int unsigned qd;
      int unsigned an;
      int unsigned cut;
      logic [15:0] hdr_qd;
      logic [15:0] hdr_an;
      logic [3:0]  rc;
      frame.delete();
      if (shape == MSG_NOISE) begin
         repeat ($urandom_range(1, 20)) put_byte(rnd8());
         return;
      end
      qd     = $urandom_range(0, 2);
      an     = $urandom_range(0, 3);
      hdr_qd = 16'(qd);
      hdr_an = 16'(an);
      rc     = (shape == MSG_RCODE) ? 4'($urandom_range(1, 15)) : 4'd0;
      if (shape == MSG_MISCOUNT) begin
         case ($urandom_range(0, 3))
            0: hdr_qd = hdr_qd + 16'd1;
            1: hdr_an = hdr_an + 16'($urandom_range(1, 2));
            2: hdr_an = hdr_an - 16'd1;
            default: hdr_qd = {rnd8(), rnd8()};
         endcase
      end
      put_byte(rnd8());
      put_byte(rnd8());
      put_byte(rnd8());
      put_byte({4'($urandom_range(0, 15)), rc});
      put_byte(hdr_qd[15:8]);
      put_byte(hdr_qd[7:0]);
      put_byte(hdr_an[15:8]);
      put_byte(hdr_an[7:0]);
      repeat (4) put_byte(rnd8());
      repeat (qd) begin
         add_name();
         repeat (4) put_byte(rnd8());
      end
      repeat (an) add_answer();
      // authority or additional bytes, not parsed
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) put_byte(rnd8());
      if (shape == MSG_CUT && frame.size() > 1) begin
         cut = $urandom_range(1, frame.size() - 1);
         while (frame.size() > cut) void'(frame.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic send_byte(input logic [7:0] value, input logic last, input bit typed);
      int gap;
      int n;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < req_idle_pct) gap = $urandom_range(1, 13);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = parse_dns_byte(value, last);
      for (int k = 0; k < n; k++) begin
         if (typed) begin
            pending_reports.insert(pending_reports.size(), directed_reports[typed_idx]);
            typed_idx++;
         end else begin
            pending_reports.insert(pending_reports.size(), byte_reports[k]);
         end
      end
      bytes_sent++;
      if (last) frames_sent++;
   endtask

   task automatic send_frame();
      req_idle_pct  = pick_rate();
      rsp_stall_pct = pick_rate();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1, 1'b0);
   endtask

   // ---------------------------------------------------------------- result side

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_stall_pct) stall_left <= $urandom_range(1, 13);
      end
   end

   always @(posedge clock) begin : check_reports
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{kind_type'(rsp_tuser), rsp_tdata[31:0], rsp_tdata[63:32],
                 rsp_tdata[67:64], rsp_tdata[83:68], rsp_tlast};
         kind_seen[rsp_tuser]++;
         if (pending_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected beat kind %0d ttl %h addr %h rcode %h found %0d last %b",
                        $time, got.kind, got.ttl, got.ipv4_address, got.response_code,
                        got.records_found, got.last_of_run);
         end else begin
            want = pending_reports.pop_front();
            if (got.kind !== want.kind || got.ttl !== want.ttl ||
                got.ipv4_address !== want.ipv4_address ||
                got.response_code !== want.response_code ||
                got.records_found !== want.records_found ||
                got.last_of_run !== want.last_of_run) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: mismatch, exp kind %0d ttl %h addr %h rcode %h found %0d last %b",
                           $time, want.kind, want.ttl, want.ipv4_address, want.response_code,
                           want.records_found, want.last_of_run);
                  $display("%0t:           got kind %0d ttl %h addr %h rcode %h found %0d last %b",
                           $time, got.kind, got.ttl, got.ipv4_address, got.response_code,
                           got.records_found, got.last_of_run);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      int            loop_frames;
      msg_shape_type shape;
      clear_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_byte(directed_rows[i][7:0], directed_rows[i][8], 1'b1);

      loop_frames = frames_sent;
      while (bytes_sent < 750 || frames_sent - loop_frames < 12) begin
         case ($urandom_range(0, 19))
            0, 1:    shape = MSG_RCODE;
            2, 3, 4: shape = MSG_CUT;
            5, 6:    shape = MSG_MISCOUNT;
            7:       shape = MSG_NOISE;
            default: shape = MSG_CLEAN;
         endcase
         build_message(shape);
         send_frame();
      end

      // back-to-back tail, no stalls either side
      quiet <= 1'b1;
      repeat (4) begin
         build_message(MSG_CLEAN);
         send_frame();
      end
      req_tvalid <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d frames, %0d bytes: clean, cut, miscounted, rcode and noise frames",
               frames_sent, bytes_sent);
      $display("Beats seen: %0d A records, %0d clean ends, %0d rcode ends, %0d bad ends",
               kind_seen[KIND_A_RECORD], kind_seen[KIND_END_OK],
               kind_seen[KIND_END_RCODE], kind_seen[KIND_END_BAD]);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failing beats", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #(8_000_000);
      $display("timeout, %0d reports still pending", pending_reports.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

### dns_response_a_record_parser_core.f
+incdir+hw/rtl
hw/rtl/dnsp_pkg.sv
hw/rtl/dnsp_parser.sv
hw/rtl/dnsp_res_queue.sv
hw/rtl/dns_response_a_record_parser_core.sv
test/testbench.sv
